// File: rtl/core/abtc_pkg.sv
`timescale 1ns / 1ps
// Package for the adaptive bitrate tier controller: item structs, command,
// direction, status and register codes, and the sequencer state type.
// No dependencies.
package abtc_pkg;

    localparam int RATE_W  = 48;
    localparam int CNT_W32 = 32;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_OBSERVE = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam logic [1:0] REG_TIER_COUNT   = 2'd0;
    localparam logic [1:0] REG_INITIAL_TIER = 2'd1;
    localparam logic [1:0] REG_STABLE_COUNT = 2'd2;
    localparam logic [1:0] REG_MIN_INTERVAL = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0]        tier;
        logic [RATE_W-1:0] rate_bps;
        logic [RATE_W-1:0] now_ms;
    } abtc_in_t;

    typedef struct packed {
        logic               status;
        logic [2:0]         selected_tier;
        logic [1:0]         direction;
        logic [CNT_W32-1:0] total_switches;
        logic [CNT_W32-1:0] up_switches;
        logic [CNT_W32-1:0] down_switches;
    } abtc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DN_SCAN,
        ST_DN_CMP,
        ST_MIN_SCAN,
        ST_DN_END,
        ST_UP_SCAN,
        ST_UP_CMP,
        ST_UP_QUAL,
        ST_TIME_SUB,
        ST_TIME_CMP,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/core/abtc_sub_unit.sv
`timescale 1ns / 1ps
// Shared 48-bit subtract unit: difference and borrow, borrow meaning a < b.
// Depends on abtc_pkg.
module abtc_sub_unit (
    input  logic [abtc_pkg::RATE_W-1:0] a,
    input  logic [abtc_pkg::RATE_W-1:0] b,
    output logic [abtc_pkg::RATE_W-1:0] diff,
    output logic                        borrow
);

    logic [abtc_pkg::RATE_W:0] full;

    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[abtc_pkg::RATE_W-1:0];
    assign borrow = full[abtc_pkg::RATE_W];

endmodule

// File: rtl/core/adaptive_bitrate_tier_controller_unit.sv
`timescale 1ns / 1ps
// Adaptive bitrate tier controller top level. Load, restart and unused items go from idle
// to the finish state, which registers the result and raises out_valid once the output is
// free. An observe item scans the ladder through one shared subtract unit, one entry read
// per cycle; a new item is taken only in idle, and a stalled result holds the sequencer and
// in_ready low. Reset marks every ladder entry unloaded (read as zero), zeroes the session
// and sets tier count 1, stable count 1, the rest 0. Depends on abtc_pkg and abtc_sub_unit.
module adaptive_bitrate_tier_controller_unit #(
    parameter int MAX_TIERS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  abtc_pkg::abtc_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output abtc_pkg::abtc_out_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W  = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1;
    localparam int TIER_W = (IDX_W > 3) ? IDX_W : 3;
    localparam int CMP_W  = ((TIER_W > 4) ? TIER_W : 4) + 2;
    localparam int RW     = abtc_pkg::RATE_W;

    abtc_pkg::state_t state_reg, state_next;

    logic [3:0]  tier_count_reg;
    logic [2:0]  initial_tier_reg;
    logic [7:0]  stable_count_reg;
    logic [31:0] min_interval_reg;

    logic [RW-1:0]        tier_rate_mem [MAX_TIERS];
    logic [MAX_TIERS-1:0] tier_vld_reg;
    logic [RW-1:0]        rd_data_reg;
    logic                 rd_vld_reg;
    logic [RW-1:0]        rate_rd;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TIER_W-1:0] cur_tier_reg, cur_tier_next;
    logic [7:0]        up_count_reg, up_count_next;
    logic [RW-1:0]     last_sw_reg, last_sw_next;
    logic [31:0]       total_reg, total_next;
    logic [31:0]       up_sw_reg, up_sw_next;
    logic [31:0]       down_sw_reg, down_sw_next;
    logic [RW-1:0]     meas_reg, meas_next;
    logic [RW-1:0]     now_reg, now_next;
    logic [RW-1:0]     cur_rate_reg, cur_rate_next;
    logic [RW-1:0]     best_rate_reg, best_rate_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;
    logic [RW-1:0]     diff_reg, diff_next;
    logic [1:0]        dir_reg, dir_next;
    logic              out_valid_reg;
    abtc_pkg::abtc_out_t out_data_reg;

    logic [RW-1:0] sub_a, sub_b, sub_diff;
    logic          sub_borrow;

    logic       accept;
    logic       cfg_wr;
    logic       load_wr;
    logic       state_ok;
    logic       idx_last;
    logic       out_free;
    logic       qual;
    logic [7:0] cnt_up;
    logic [7:0] need;
    logic       climb_try;

    abtc_sub_unit u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == abtc_pkg::ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign load_wr  = accept && (in_data.cmd == abtc_pkg::CMD_LOAD)
                      && (CMP_W'(in_data.tier) < CMP_W'(MAX_TIERS));
    assign out_free = !out_valid_reg || out_ready;
    assign rate_rd  = rd_vld_reg ? rd_data_reg : '0;

    assign state_ok = (tier_count_reg != 4'd0)
                      && (CMP_W'(tier_count_reg) <= CMP_W'(MAX_TIERS))
                      && (CMP_W'(cur_tier_reg) < CMP_W'(tier_count_reg));
    assign idx_last = (CMP_W'(idx_reg) == (CMP_W'(tier_count_reg) - CMP_W'(1)));

    assign qual      = found_reg && !sub_borrow;
    assign cnt_up    = qual ? ((up_count_reg == 8'hFF) ? 8'hFF : up_count_reg + 8'd1)
                            : 8'd0;
    assign need      = (stable_count_reg == 8'd0) ? 8'd1 : stable_count_reg;
    assign climb_try = found_reg && (cnt_up >= need);

    always_comb
    begin
        case (paddr[3:2])
            abtc_pkg::REG_TIER_COUNT:   prdata = {28'd0, tier_count_reg};
            abtc_pkg::REG_INITIAL_TIER: prdata = {29'd0, initial_tier_reg};
            abtc_pkg::REG_STABLE_COUNT: prdata = {24'd0, stable_count_reg};
            abtc_pkg::REG_MIN_INTERVAL: prdata = min_interval_reg;
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            abtc_pkg::ST_FETCH:    begin sub_a = meas_reg;      sub_b = rate_rd;       end
            abtc_pkg::ST_DN_SCAN:  begin sub_a = meas_reg;      sub_b = rate_rd;       end
            abtc_pkg::ST_DN_CMP:   begin sub_a = best_rate_reg; sub_b = rate_rd;       end
            abtc_pkg::ST_MIN_SCAN: begin sub_a = rate_rd;       sub_b = best_rate_reg; end
            abtc_pkg::ST_UP_SCAN:  begin sub_a = cur_rate_reg;  sub_b = rate_rd;       end
            abtc_pkg::ST_UP_CMP:   begin sub_a = rate_rd;       sub_b = best_rate_reg; end
            abtc_pkg::ST_UP_QUAL:  begin sub_a = meas_reg;      sub_b = best_rate_reg; end
            abtc_pkg::ST_TIME_SUB: begin sub_a = now_reg;       sub_b = last_sw_reg;   end
            abtc_pkg::ST_TIME_CMP: begin sub_a = diff_reg;      sub_b = RW'(min_interval_reg); end
            default:               begin sub_a = '0;            sub_b = '0;            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            abtc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == abtc_pkg::CMD_OBSERVE && state_ok)
                        state_next = abtc_pkg::ST_FETCH;
                    else
                        state_next = abtc_pkg::ST_FINISH;
                end
            end
            abtc_pkg::ST_FETCH:
                state_next = sub_borrow ? abtc_pkg::ST_DN_SCAN : abtc_pkg::ST_UP_SCAN;
            abtc_pkg::ST_DN_SCAN:
            begin
                if (!sub_borrow && found_reg)
                    state_next = abtc_pkg::ST_DN_CMP;
                else if (idx_last)
                    state_next = (found_reg || !sub_borrow) ? abtc_pkg::ST_DN_END
                                                            : abtc_pkg::ST_MIN_SCAN;
            end
            abtc_pkg::ST_DN_CMP:
                state_next = idx_last ? abtc_pkg::ST_DN_END : abtc_pkg::ST_DN_SCAN;
            abtc_pkg::ST_MIN_SCAN:
            begin
                if (idx_last)
                    state_next = abtc_pkg::ST_DN_END;
            end
            abtc_pkg::ST_DN_END:
                state_next = abtc_pkg::ST_FINISH;
            abtc_pkg::ST_UP_SCAN:
            begin
                if (sub_borrow && found_reg)
                    state_next = abtc_pkg::ST_UP_CMP;
                else if (idx_last)
                    state_next = abtc_pkg::ST_UP_QUAL;
            end
            abtc_pkg::ST_UP_CMP:
                state_next = idx_last ? abtc_pkg::ST_UP_QUAL : abtc_pkg::ST_UP_SCAN;
            abtc_pkg::ST_UP_QUAL:
                state_next = climb_try ? abtc_pkg::ST_TIME_SUB : abtc_pkg::ST_FINISH;
            abtc_pkg::ST_TIME_SUB:
                state_next = sub_borrow ? abtc_pkg::ST_FINISH : abtc_pkg::ST_TIME_CMP;
            abtc_pkg::ST_TIME_CMP:
                state_next = abtc_pkg::ST_FINISH;
            abtc_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = abtc_pkg::ST_IDLE;
            end
            default:
                state_next = abtc_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        idx_next       = idx_reg;
        cur_tier_next  = cur_tier_reg;
        up_count_next  = up_count_reg;
        last_sw_next   = last_sw_reg;
        total_next     = total_reg;
        up_sw_next     = up_sw_reg;
        down_sw_next   = down_sw_reg;
        meas_next      = meas_reg;
        now_next       = now_reg;
        cur_rate_next  = cur_rate_reg;
        best_rate_next = best_rate_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        diff_next      = diff_reg;
        dir_next       = dir_reg;
        unique case (state_reg)
            abtc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    dir_next  = abtc_pkg::DIR_NONE;
                    meas_next = in_data.rate_bps;
                    now_next  = in_data.now_ms;
                    idx_next  = IDX_W'(cur_tier_reg);
                    if (in_data.cmd == abtc_pkg::CMD_RESTART)
                    begin
                        cur_tier_next = TIER_W'(initial_tier_reg);
                        up_count_next = '0;
                        last_sw_next  = '0;
                        total_next    = '0;
                        up_sw_next    = '0;
                        down_sw_next  = '0;
                    end
                end
            end
            abtc_pkg::ST_FETCH:
            begin
                cur_rate_next = rate_rd;
                found_next    = 1'b0;
                idx_next      = '0;
            end
            abtc_pkg::ST_DN_SCAN:
            begin
                if (!sub_borrow && !found_reg)
                begin
                    best_next      = idx_reg;
                    best_rate_next = rate_rd;
                    found_next     = 1'b1;
                end
                if (!(!sub_borrow && found_reg))
                begin
                    if (!idx_last)
                        idx_next = idx_reg + IDX_W'(1);
                    else if (!(found_reg || !sub_borrow))
                        idx_next = '0;
                end
            end
            abtc_pkg::ST_DN_CMP:
            begin
                if (sub_borrow)
                begin
                    best_next      = idx_reg;
                    best_rate_next = rate_rd;
                end
                if (!idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            abtc_pkg::ST_MIN_SCAN:
            begin
                if (idx_reg == '0 || sub_borrow)
                begin
                    best_next      = idx_reg;
                    best_rate_next = rate_rd;
                end
                if (!idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            abtc_pkg::ST_DN_END:
            begin
                if (TIER_W'(best_reg) != cur_tier_reg)
                begin
                    cur_tier_next = TIER_W'(best_reg);
                    up_count_next = '0;
                    last_sw_next  = now_reg;
                    total_next    = total_reg + 32'd1;
                    down_sw_next  = down_sw_reg + 32'd1;
                    dir_next      = abtc_pkg::DIR_DOWN;
                end
            end
            abtc_pkg::ST_UP_SCAN:
            begin
                if (sub_borrow && !found_reg)
                begin
                    best_next      = idx_reg;
                    best_rate_next = rate_rd;
                    found_next     = 1'b1;
                end
                if (!(sub_borrow && found_reg) && !idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            abtc_pkg::ST_UP_CMP:
            begin
                if (sub_borrow)
                begin
                    best_next      = idx_reg;
                    best_rate_next = rate_rd;
                end
                if (!idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            abtc_pkg::ST_UP_QUAL:
                up_count_next = cnt_up;
            abtc_pkg::ST_TIME_SUB:
                diff_next = sub_diff;
            abtc_pkg::ST_TIME_CMP:
            begin
                if (!sub_borrow)
                begin
                    cur_tier_next = TIER_W'(best_reg);
                    up_count_next = '0;
                    last_sw_next  = now_reg;
                    total_next    = total_reg + 32'd1;
                    up_sw_next    = up_sw_reg + 32'd1;
                    dir_next      = abtc_pkg::DIR_UP;
                end
            end
            abtc_pkg::ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ladder storage
    always_ff @(posedge clk)
    begin
        if (load_wr)
            tier_rate_mem[IDX_W'(in_data.tier)] <= in_data.rate_bps;
        rd_data_reg <= tier_rate_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (load_wr)
                tier_vld_reg[IDX_W'(in_data.tier)] <= 1'b1;
            rd_vld_reg <= tier_vld_reg[idx_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_count_reg   <= 4'd1;
            initial_tier_reg <= 3'd0;
            stable_count_reg <= 8'd1;
            min_interval_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                abtc_pkg::REG_TIER_COUNT:   tier_count_reg   <= pwdata[3:0];
                abtc_pkg::REG_INITIAL_TIER: initial_tier_reg <= pwdata[2:0];
                abtc_pkg::REG_STABLE_COUNT: stable_count_reg <= pwdata[7:0];
                abtc_pkg::REG_MIN_INTERVAL: min_interval_reg <= pwdata;
                default:                    tier_count_reg   <= tier_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abtc_pkg::ST_IDLE;
            idx_reg       <= '0;
            cur_tier_reg  <= '0;
            up_count_reg  <= '0;
            last_sw_reg   <= '0;
            total_reg     <= '0;
            up_sw_reg     <= '0;
            down_sw_reg   <= '0;
            found_reg     <= 1'b0;
            dir_reg       <= abtc_pkg::DIR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cur_tier_reg <= cur_tier_next;
            up_count_reg <= up_count_next;
            last_sw_reg  <= last_sw_next;
            total_reg    <= total_next;
            up_sw_reg    <= up_sw_next;
            down_sw_reg  <= down_sw_next;
            found_reg    <= found_next;
            dir_reg      <= dir_next;
            if (state_reg == abtc_pkg::ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg      <= meas_next;
        now_reg       <= now_next;
        cur_rate_reg  <= cur_rate_next;
        best_rate_reg <= best_rate_next;
        best_reg      <= best_next;
        diff_reg      <= diff_next;
        if (state_reg == abtc_pkg::ST_FINISH && out_free)
        begin
            out_data_reg.status         <= state_ok ? abtc_pkg::STATUS_OK
                                                    : abtc_pkg::STATUS_INVALID;
            out_data_reg.selected_tier  <= cur_tier_reg[2:0];
            out_data_reg.direction      <= dir_reg;
            out_data_reg.total_switches <= total_reg;
            out_data_reg.up_switches    <= up_sw_reg;
            out_data_reg.down_switches  <= down_sw_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: bench/abtc_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the adaptive bitrate tier controller bench: a tier-ladder
// predictor and the queue of expected results it feeds.
// Depends on abtc_pkg.
package abtc_check_pkg;

    import abtc_pkg::*;

    localparam int LADDER_DEPTH = 8;
    localparam int REPORT_CAP   = 200;

    class tier_scoreboard;

        logic [RATE_W-1:0]  ladder [LADDER_DEPTH];
        logic [2:0]         cur_tier;
        logic [7:0]         climb_votes;
        logic [RATE_W-1:0]  last_move_ms;
        logic [31:0]        total_sw;
        logic [31:0]        up_sw;
        logic [31:0]        down_sw;

        logic [3:0]         cfg_tiers;
        logic [2:0]         cfg_initial;
        logic [7:0]         cfg_stable;
        logic [31:0]        cfg_gap;

        abtc_out_t          expected_q [$];
        int                 errors;
        int                 n_checked;
        int                 n_climbs;
        int                 n_drops;
        int                 n_invalid;

        function new();
            cfg_tiers   = 4'd1;
            cfg_initial = 3'd0;
            cfg_stable  = 8'd1;
            cfg_gap     = 32'd0;
            for (int i = 0; i < LADDER_DEPTH; i++)
                ladder[i] = '0;
            errors    = 0;
            n_checked = 0;
            n_climbs  = 0;
            n_drops   = 0;
            n_invalid = 0;
            restart_session();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TIER_COUNT:   cfg_tiers   = value[3:0];
                REG_INITIAL_TIER: cfg_initial = value[2:0];
                REG_STABLE_COUNT: cfg_stable  = value[7:0];
                REG_MIN_INTERVAL: cfg_gap     = value;
                default: ;
            endcase
        endfunction

        function bit session_ok();
            return cfg_tiers >= 1 && cfg_tiers <= LADDER_DEPTH && cur_tier < cfg_tiers;
        endfunction

        function void restart_session();
            cur_tier     = cfg_initial;
            climb_votes  = '0;
            last_move_ms = '0;
            total_sw     = '0;
            up_sw        = '0;
            down_sw      = '0;
        endfunction

        function logic [1:0] observe(logic [RATE_W-1:0] meas, logic [RATE_W-1:0] now);
            int                n;
            int                best;
            int                nxt;
            int                need;
            bit                found;
            bit                have;
            logic [RATE_W-1:0] cur_rate;

            n        = cfg_tiers;
            cur_rate = ladder[cur_tier];
            if (meas < cur_rate) begin
                best  = 0;
                found = 1'b0;
                for (int i = 0; i < n; i++)
                    if (ladder[i] <= meas && (!found || ladder[i] > ladder[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                if (!found) begin
                    best = 0;
                    for (int i = 1; i < n; i++)
                        if (ladder[i] < ladder[best])
                            best = i;
                end
                if (best != cur_tier) begin
                    cur_tier     = 3'(best);
                    climb_votes  = '0;
                    last_move_ms = now;
                    total_sw++;
                    down_sw++;
                    n_drops++;
                    return DIR_DOWN;
                end
                return DIR_NONE;
            end

            need = (cfg_stable == 0) ? 1 : cfg_stable;
            nxt  = 0;
            have = 1'b0;
            for (int i = 0; i < n; i++)
                if (ladder[i] > cur_rate && (!have || ladder[i] < ladder[nxt])) begin
                    nxt  = i;
                    have = 1'b1;
                end
            if (have && meas >= ladder[nxt]) begin
                if (climb_votes != 8'hFF)
                    climb_votes++;
            end else begin
                climb_votes = '0;
            end
            if (have && climb_votes >= need && now >= last_move_ms &&
                (now - last_move_ms) >= {16'd0, cfg_gap}) begin
                cur_tier     = 3'(nxt);
                climb_votes  = '0;
                last_move_ms = now;
                total_sw++;
                up_sw++;
                n_climbs++;
                return DIR_UP;
            end
            return DIR_NONE;
        endfunction

        function void note_input(abtc_in_t item);
            abtc_out_t  want;
            logic [1:0] dir;

            dir = DIR_NONE;
            case (item.cmd)
                CMD_LOAD:    ladder[item.tier] = item.rate_bps;
                CMD_OBSERVE: if (session_ok()) dir = observe(item.rate_bps, item.now_ms);
                CMD_RESTART: restart_session();
                default: ;
            endcase
            want.status         = session_ok() ? STATUS_OK : STATUS_INVALID;
            want.selected_tier  = cur_tier;
            want.direction      = dir;
            want.total_switches = total_sw;
            want.up_switches    = up_sw;
            want.down_switches  = down_sw;
            if (want.status == STATUS_INVALID)
                n_invalid++;
            expected_q.push_back(want);
        endfunction

        function void flag(string name, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        endfunction

        function void check_result(abtc_out_t got);
            abtc_out_t want;

            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result with none due, expected nothing, got %0h",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.status !== got.status)
                flag("status", want.status, got.status);
            if (want.selected_tier !== got.selected_tier)
                flag("selected_tier", want.selected_tier, got.selected_tier);
            if (want.direction !== got.direction)
                flag("direction", want.direction, got.direction);
            if (want.total_switches !== got.total_switches)
                flag("total_switches", want.total_switches, got.total_switches);
            if (want.up_switches !== got.up_switches)
                flag("up_switches", want.up_switches, got.up_switches);
            if (want.down_switches !== got.down_switches)
                flag("down_switches", want.down_switches, got.down_switches);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top-level bench for adaptive_bitrate_tier_controller_unit: directed and random
// ladder, observe, restart and unused items checked against the tier scoreboard.
// Depends on abtc_pkg, abtc_check_pkg and the controller RTL.
module tb;

    import abtc_pkg::*;
    import abtc_check_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 500000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    abtc_in_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    abtc_out_t         out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [3:0]        paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    tier_scoreboard    sb = new();

    int                items_sent    = 0;
    int                setting_count = 0;
    int                burst_left    = 0;
    bit                tx_quiet      = 1'b0;
    logic [RATE_W-1:0] clock_ms      = '0;
    int                cycle_count   = 0;
    int                rx_hold       = 0;
    int                rx_mode       = 0;
    int                rx_span       = 0;

    adaptive_bitrate_tier_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold > 0) begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end else begin
            out_ready <= 1'b1;
            if (rx_mode != 0 && $urandom_range(0, 99) < (rx_mode == 1 ? 15 : 45))
                rx_hold <= $urandom_range(1, rx_mode == 1 ? 3 : 8);
        end
        if (rx_span == 150) begin
            rx_span <= 0;
            rx_mode <= $urandom_range(0, 2);
        end else begin
            rx_span <= rx_span + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic logic [RATE_W-1:0] wide_rand();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[RATE_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        logic [RATE_W-1:0] top;
        logic [RATE_W-1:0] r;

        top = '0;
        for (int i = 0; i < LADDER_DEPTH; i++)
            if (sb.ladder[i] > top)
                top = sb.ladder[i];
        r = sb.ladder[$urandom_range(0, LADDER_DEPTH - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return top + RATE_W'($urandom_range(0, 2));
            4:          return r - RATE_W'(1);
            5:          return wide_rand();
            default:    return r + RATE_W'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] next_time();
        case ($urandom_range(0, 19))
            0:       clock_ms = wide_rand();
            1:       clock_ms = clock_ms - RATE_W'($urandom_range(1, 50));
            2, 3:    clock_ms = clock_ms + RATE_W'(sb.cfg_gap);
            4:       clock_ms = clock_ms + RATE_W'(sb.cfg_gap) - RATE_W'(1);
            default: clock_ms = clock_ms + RATE_W'($urandom_range(0, 12));
        endcase
        return clock_ms;
    endfunction

    task automatic send(input cmd_t c, input logic [2:0] slot,
                        input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] now);
        abtc_in_t item;
        int       gap;

        item.cmd      = c;
        item.tier     = slot;
        item.rate_bps = rate;
        item.now_ms   = now;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_quiet ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(item);
        items_sent++;
    endtask

    // drop valid and hold until every expected result is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [3:0] tiers, input logic [2:0] initial_slot,
                             input logic [7:0] stable, input logic [31:0] gap);
        apb_write(REG_TIER_COUNT, {28'd0, tiers});
        apb_write(REG_INITIAL_TIER, {29'd0, initial_slot});
        apb_write(REG_STABLE_COUNT, {24'd0, stable});
        apb_write(REG_MIN_INTERVAL, gap);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        setting_count++;
    endtask

    task automatic run_phase();
        logic [3:0]        tiers;
        logic [7:0]        stable;
        logic [31:0]       gap;
        logic [2:0]        rot;
        logic [RATE_W-1:0] base;
        logic [RATE_W-1:0] step;
        logic [RATE_W-1:0] rate;
        int                style;
        int                len;

        wait_idle();
        tx_quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0:       tiers = 4'd0;
            1:       tiers = 4'($urandom_range(9, 15));
            2:       tiers = 4'd8;
            3:       tiers = 4'd1;
            default: tiers = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
            0:       stable = 8'd0;
            1:       stable = 8'd255;
            2:       stable = 8'($urandom_range(1, 255));
            default: stable = 8'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 7))
            0:       gap = 32'd0;
            1:       gap = 32'hFFFF_FFFF;
            2:       gap = $urandom;
            default: gap = $urandom_range(0, 40);
        endcase
        configure(tiers, 3'($urandom_range(0, 7)), stable, gap);

        style = $urandom_range(0, 3);
        rot   = 3'($urandom_range(0, 7));
        base  = RATE_W'($urandom_range(1, 1000));
        step  = RATE_W'($urandom_range(0, 500));
        if (style != 3)
            for (int i = 0; i < LADDER_DEPTH; i++) begin
                case (style)
                    0:       rate = base + step * RATE_W'(i);
                    1:       rate = RATE_W'($urandom_range(0, 20));
                    default: rate = wide_rand();
                endcase
                send(CMD_LOAD, 3'(i) ^ rot, rate, wide_rand());
            end
        send(CMD_RESTART, 3'($urandom_range(0, 7)), wide_rand(), wide_rand());

        clock_ms = ($urandom_range(0, 4) == 0) ? wide_rand()
                                                : RATE_W'($urandom_range(0, 1000));
        len = $urandom_range(30, 80);
        repeat (len) begin
            case ($urandom_range(0, 24))
                0: send(CMD_UNUSED, 3'($urandom_range(0, 7)), wide_rand(), wide_rand());
                1: send(CMD_LOAD, 3'($urandom_range(0, 7)), pick_rate(), wide_rand());
                2: send(CMD_RESTART, 3'($urandom_range(0, 7)), wide_rand(), wide_rand());
                3: send(CMD_OBSERVE, 3'($urandom_range(0, 7)), wide_rand(), wide_rand());
                default:
                    send(CMD_OBSERVE, 3'($urandom_range(0, 7)), pick_rate(), next_time());
            endcase
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one tier, empty ladder
        send(CMD_OBSERVE, 3'd0, '0, '0);
        send(CMD_UNUSED, 3'd7, '1, '1);
        send(CMD_LOAD, 3'd7, '1, '0);
        send(CMD_OBSERVE, 3'd5, '1, '1);
        send(CMD_RESTART, 3'd0, '0, '0);

        // full ladder with ties, start from the top tier
        wait_idle();
        configure(4'd8, 3'd7, 8'd0, 32'd0);
        send(CMD_LOAD, 3'd0, 48'd1000, '0);
        send(CMD_LOAD, 3'd1, 48'd2000, '0);
        send(CMD_LOAD, 3'd2, 48'd2000, '0);
        send(CMD_LOAD, 3'd3, 48'd4000, '0);
        send(CMD_LOAD, 3'd4, 48'd500, '0);
        send(CMD_LOAD, 3'd5, 48'd8000, '0);
        send(CMD_LOAD, 3'd6, 48'd8000, '0);
        send(CMD_RESTART, 3'd0, '0, '0);
        send(CMD_OBSERVE, 3'd0, 48'd3000, 48'd10);
        send(CMD_OBSERVE, 3'd0, 48'd100, 48'd20);
        send(CMD_OBSERVE, 3'd0, 48'd600, 48'd30);
        send(CMD_OBSERVE, 3'd0, 48'd1000, 48'd30);
        send(CMD_OBSERVE, 3'd0, 48'd2000, 48'd5);
        send(CMD_OBSERVE, 3'd0, 48'd2000, 48'd40);
        send(CMD_OBSERVE, 3'd0, '1, '1);
        send(CMD_OBSERVE, 3'd0, '0, '0);

        // unusable tier counts and a current tier beyond the count
        wait_idle();
        configure(4'd0, 3'd7, 8'd255, 32'hFFFF_FFFF);
        send(CMD_OBSERVE, 3'd0, 48'd5000, 48'd100);
        wait_idle();
        configure(4'd15, 3'd7, 8'd255, 32'hFFFF_FFFF);
        send(CMD_OBSERVE, 3'd0, 48'd5000, 48'd200);
        wait_idle();
        configure(4'd3, 3'd7, 8'd255, 32'hFFFF_FFFF);
        send(CMD_OBSERVE, 3'd0, 48'd5000, 48'd300);
        send(CMD_RESTART, 3'd0, '0, '0);

        // saturate the climb count while the interval holds the switch back
        wait_idle();
        configure(4'd8, 3'd0, 8'd255, 32'd1000);
        for (int i = 0; i < LADDER_DEPTH; i++)
            send(CMD_LOAD, 3'(i), 48'(100 * (i + 1)), '0);
        send(CMD_RESTART, 3'd0, '0, '0);
        repeat (270) send(CMD_OBSERVE, 3'($urandom_range(0, 7)), 48'd900, 48'd500);
        send(CMD_OBSERVE, 3'd0, 48'd900, 48'd1500);
        send(CMD_OBSERVE, 3'd0, 48'd900, 48'd1501);

        while (items_sent < RANDOM_ITEMS)
            run_phase();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d items over %0d register settings, %0d results checked",
                 items_sent, setting_count, sb.n_checked);
        $display("predicted %0d climbs, %0d drops and %0d invalid-status results",
                 sb.n_climbs, sb.n_drops, sb.n_invalid);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
